[hdl/gpbc_pkg.sv]
package gpbc_pkg;

   // Default depth of the curve point table
   localparam int CURVE_DEPTH_DEFAULT = 4096;

   // Fixed field widths of the item and configuration ports
   localparam int COORD_W     = 32;
   localparam int INDEX_W     = 12;
   localparam int COUNT_REG_W = 13;

   typedef enum logic {
      OP_LOAD     = 1'b0,
      OP_CLASSIFY = 1'b1
   } op_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic write_point;   // write the item's point into the curve table
      logic load_item;     // capture a classify item and open the search window
      logic search;        // take one binary search step
      logic fetch;         // read both ends of the bracketing segment
      logic diff;          // form differences, magnitudes and signs
      logic mul;           // form both cross products
      logic emit;          // compare products and present the result
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic search_done;   // search window has closed
   } dp_status_type;

endpackage

[hdl/grid_point_below_curve_classifier_top.sv]
// Classifies grid points against a piecewise-linear curve held in an on-chip
// table of (x, y) points, x ascending, all signed Q16.16. A load item
// (operation 0) writes one table entry and gives no result; busy stays low,
// and an index at or above CURVE_DEPTH is dropped. A classify item (operation
// 1) binary-searches the first csr points_in_use entries for the first x at or
// above the point's x, then tests the point strictly below the chord of the
// bracketing segment by exact cross-multiplication, with no rounding. The
// search takes s steps, one table read per cycle, s at most ceil(log2(n + 1))
// for n points in use (13 for 4096), and busy stays high through the search,
// search close, segment fetch, difference, multiply and compare steps. The
// result appears on the rsp_ ports for exactly one cycle with rsp_valid high,
// in the first cycle with busy low; a new item may be started in that same
// cycle. The receiver cannot stall: capture the result when rsp_valid is high.
// Write points_in_use only while busy is low and no result is pending; a count
// above CURVE_DEPTH acts as CURVE_DEPTH. The table is not cleared at reset, so
// load every entry in use before classifying.
module grid_point_below_curve_classifier_top
   import gpbc_pkg::*;
#(
   parameter int CURVE_DEPTH = CURVE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_operation,
   input  logic [INDEX_W-1:0]     req_point_index,
   input  logic [COORD_W-1:0]     req_coord_x,
   input  logic [COORD_W-1:0]     req_coord_y,
   output logic                   rsp_valid,
   output logic [COORD_W-1:0]     rsp_point_x,
   output logic [COORD_W-1:0]     rsp_point_y,
   output logic                   rsp_is_solid,
   output logic                   rsp_outside_span,
   input  logic                   csr_write_enable,
   input  logic [COUNT_REG_W-1:0] csr_write_data
);

   localparam int ADDR_W = $clog2(CURVE_DEPTH);
   localparam int CNT_W  = $clog2(CURVE_DEPTH + 1);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Point count register; clamp to the table depth before use
   logic [COUNT_REG_W-1:0] points_in_use_ff;
   logic [CNT_W-1:0]       curve_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_in_use_ff <= '0;
      end else if (csr_write_enable) begin
         points_in_use_ff <= csr_write_data;
      end
   end

   assign curve_count = (32'(points_in_use_ff) > 32'(CURVE_DEPTH)) ?
                        CNT_W'(CURVE_DEPTH) : CNT_W'(points_in_use_ff);

   gpbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_operation),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   gpbc_datapath #(
      .CURVE_DEPTH (CURVE_DEPTH),
      .ADDR_W      (ADDR_W),
      .CNT_W       (CNT_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .curve_count      (curve_count),
      .point_index      (req_point_index),
      .coord_x          (req_coord_x),
      .coord_y          (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_is_solid     (rsp_is_solid),
      .rsp_outside_span (rsp_outside_span)
   );

   // A classify item must hold the block busy in the next cycle
   a_classify_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (op_type'(req_operation) == OP_CLASSIFY)) |=> busy)
      else $error("classify item accepted without going busy");

   // A result closes a classify: busy just fell
   a_result_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of a classify");

endmodule

[hdl/gpbc_ctrl.sv]
module gpbc_ctrl
   import gpbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          operation,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEARCH = 6'b000010,
      ST_FETCH  = 6'b000100,
      ST_DIFF   = 6'b001000,
      ST_MUL    = 6'b010000,
      ST_CMP    = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (op_type'(operation) == OP_CLASSIFY) begin
                  cmd.load_item = 1'b1;
                  state_in      = ST_SEARCH;
               end else begin
                  cmd.write_point = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (status.search_done) begin
               state_in = ST_FETCH;
            end else begin
               cmd.search = 1'b1;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[hdl/gpbc_datapath.sv]
module gpbc_datapath
   import gpbc_pkg::*;
#(
   parameter int CURVE_DEPTH = CURVE_DEPTH_DEFAULT,
   parameter int ADDR_W      = $clog2(CURVE_DEPTH),
   parameter int CNT_W       = $clog2(CURVE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [CNT_W-1:0]    curve_count,
   input  logic [INDEX_W-1:0]  point_index,
   input  logic [COORD_W-1:0]  coord_x,
   input  logic [COORD_W-1:0]  coord_y,
   output logic                rsp_valid,
   output logic [COORD_W-1:0]  rsp_point_x,
   output logic [COORD_W-1:0]  rsp_point_y,
   output logic                rsp_is_solid,
   output logic                rsp_outside_span
);

   localparam int PROD_W = 2 * COORD_W;

   // Magnitude of an exact 33-bit difference; always fits in 32 bits
   function automatic logic [COORD_W-1:0] mag33(input logic [COORD_W:0] v);
      logic [COORD_W:0] neg;
      neg = -v;
      return v[COORD_W] ? neg[COORD_W-1:0] : v[COORD_W-1:0];
   endfunction

   // Signed-magnitude a < b, with negative zero read as zero
   function automatic logic sm_less(input logic a_neg, input logic [PROD_W-1:0] a_mag,
                                    input logic b_neg, input logic [PROD_W-1:0] b_mag);
      logic an;
      logic bn;
      an = a_neg && (a_mag != '0);
      bn = b_neg && (b_mag != '0);
      if (an != bn) begin
         return an;
      end
      return an ? (a_mag > b_mag) : (a_mag < b_mag);
   endfunction

   // Curve table
   logic [COORD_W-1:0] x_mem [CURVE_DEPTH];
   logic [COORD_W-1:0] y_mem [CURVE_DEPTH];

   logic [COORD_W-1:0] rd_xa_ff, rd_xb_ff, rd_ya_ff, rd_yb_ff;
   logic [ADDR_W-1:0]  addr_a, addr_b, wr_addr;
   logic               wr_ok;

   // Search window and captured point
   logic [CNT_W-1:0]   lo_ff, lo_in, hi_ff, hi_in, mid_cur, mid_next;
   logic [CNT_W:0]     sum_cur, sum_next;
   logic [COORD_W-1:0] px_ff, py_ff;
   logic               span_ok_ff;

   // Difference stage
   logic [COORD_W:0]   d_w, dy_w, e_w, f_w;
   logic [COORD_W-1:0] mag_d_ff, mag_dy_ff, mag_e_ff, mag_f_ff;
   logic               d_neg_ff, d_zero_ff, lhs_neg_ff, rhs_neg_ff;

   // Product stage
   logic [PROD_W-1:0]  lhs_ff, rhs_ff;

   // Result
   logic               rsp_valid_ff, is_solid_ff, outside_ff;
   logic               solid_w, outside_w;

   assign sum_cur = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_cur = sum_cur[CNT_W:1];

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.load_item) begin
         lo_in = '0;
         hi_in = curve_count;
      end else if (cmd.search) begin
         if ($signed(rd_xa_ff) < $signed(px_ff)) begin
            lo_in = mid_cur + CNT_W'(1);
         end else begin
            hi_in = mid_cur;
         end
      end
   end

   // Address the next midpoint so its entry is ready for the next step
   assign sum_next = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_next = sum_next[CNT_W:1];
   assign addr_a   = cmd.fetch ? ADDR_W'(lo_ff - CNT_W'(1)) : ADDR_W'(mid_next);
   assign addr_b   = ADDR_W'(lo_ff);
   assign wr_ok    = cmd.write_point && (32'(point_index) < 32'(CURVE_DEPTH));
   assign wr_addr  = ADDR_W'(point_index);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         x_mem[wr_addr] <= coord_x;
         y_mem[wr_addr] <= coord_y;
      end
      rd_xa_ff <= x_mem[addr_a];
      rd_xb_ff <= x_mem[addr_b];
      rd_ya_ff <= y_mem[addr_a];
      rd_yb_ff <= y_mem[addr_b];
   end

   assign status.search_done = (lo_ff == hi_ff);

   // Exact 33-bit differences over the bracketing segment
   assign d_w  = {rd_xb_ff[COORD_W-1], rd_xb_ff} - {rd_xa_ff[COORD_W-1], rd_xa_ff};
   assign dy_w = {py_ff[COORD_W-1], py_ff}       - {rd_ya_ff[COORD_W-1], rd_ya_ff};
   assign e_w  = {rd_yb_ff[COORD_W-1], rd_yb_ff} - {rd_ya_ff[COORD_W-1], rd_ya_ff};
   assign f_w  = {px_ff[COORD_W-1], px_ff}       - {rd_xa_ff[COORD_W-1], rd_xa_ff};

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.load_item) begin
         px_ff <= coord_x;
         py_ff <= coord_y;
      end
      if (cmd.fetch) begin
         span_ok_ff <= (lo_ff != '0) && (lo_ff != curve_count);
      end
      if (cmd.diff) begin
         mag_d_ff   <= mag33(d_w);
         mag_dy_ff  <= mag33(dy_w);
         mag_e_ff   <= mag33(e_w);
         mag_f_ff   <= mag33(f_w);
         d_neg_ff   <= d_w[COORD_W];
         d_zero_ff  <= (d_w == '0);
         lhs_neg_ff <= dy_w[COORD_W] ^ d_w[COORD_W];
         rhs_neg_ff <= e_w[COORD_W] ^ f_w[COORD_W];
      end
      if (cmd.mul) begin
         lhs_ff <= PROD_W'(mag_dy_ff) * PROD_W'(mag_d_ff);
         rhs_ff <= PROD_W'(mag_e_ff) * PROD_W'(mag_f_ff);
      end
   end

   // Reverse the test on a descending segment
   assign outside_w = !span_ok_ff || d_zero_ff;
   assign solid_w   = !outside_w &&
                      (d_neg_ff ? sm_less(rhs_neg_ff, rhs_ff, lhs_neg_ff, lhs_ff)
                                : sm_less(lhs_neg_ff, lhs_ff, rhs_neg_ff, rhs_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         is_solid_ff <= solid_w;
         outside_ff  <= outside_w;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_point_x      = px_ff;
   assign rsp_point_y      = py_ff;
   assign rsp_is_solid     = is_solid_ff;
   assign rsp_outside_span = outside_ff;

   a_search_window_open: assert property (@(posedge clock) disable iff (reset)
      cmd.search |-> (lo_ff < hi_ff))
      else $error("search step taken on a closed window");

   a_window_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> (lo_ff == '0) && (hi_ff == $past(curve_count)))
      else $error("search window not opened from the point count");

endmodule
